// ===== sv/swm_pkg.sv =====
// swm_pkg: shared widths, codes, states and control bundles of the sliding
// window median rate block
// no dependencies
package swm_pkg;

  localparam int RATE_W    = 57;
  localparam int FEE_W     = 47;
  localparam int SIZE_W    = 24;
  localparam int FILL_W    = 10;
  localparam int CFG_IDX_W = 8;
  localparam int DIV_STEPS = 57;
  localparam int STEP_W    = 6;

  localparam logic [CFG_IDX_W-1:0] REG_FALLBACK = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR    = 8'd1;

  localparam logic [RATE_W-1:0] FALLBACK_RESET = 57'd10000;
  localparam logic [RATE_W-1:0] FLOOR_RESET    = 57'd1000;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL  = 8'b0000_0010,
    S_DIV  = 8'b0000_0100,
    S_RING = 8'b0000_1000,
    S_RD   = 8'b0001_0000,
    S_CMP  = 8'b0010_0000,
    S_TAIL = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic div_step;
    logic ring;
    logic rd;
    logic cmp;
    logic tail;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic zero_size;
    logic div_last;
    logic pass_end;
  } stat_t;

  typedef struct packed {
    logic              accepted;
    logic [RATE_W-1:0] obs_rate;
    logic [RATE_W-1:0] estimate;
    logic              used_fallback;
    logic [FILL_W-1:0] fill_level;
  } result_t;

endpackage

// ===== sv/swm_ctrl.sv =====
// swm_ctrl: sequencer of the median block, one item at a time
// depends on swm_pkg
module swm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           out_busy,
  input  swm_pkg::stat_t stat,
  output logic           in_ready,
  output swm_pkg::cmd_t  cmd
);
  import swm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = stat.zero_size ? S_RING : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_RING;
        end
      end
      S_RING: begin
        cmd.ring  = 1'b1;
        state_nxt = S_RD;
      end
      S_RD: begin
        if (stat.pass_end) begin
          state_nxt = S_TAIL;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = S_RD;
      end
      S_TAIL: begin
        cmd.tail  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/swm_dpath.sv =====
// swm_dpath: rate divider, ring of recent rates and ping-pong sorted copy
// depends on swm_pkg
module swm_dpath #(
  parameter int DEPTH = 1000
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  swm_pkg::cmd_t                  cmd,
  input  logic [swm_pkg::FEE_W-1:0]      in_fee,
  input  logic [swm_pkg::SIZE_W-1:0]     in_size,
  input  logic [swm_pkg::RATE_W-1:0]     fallback_rate,
  input  logic [swm_pkg::RATE_W-1:0]     floor_rate,
  output swm_pkg::stat_t                 stat,
  output swm_pkg::result_t               res
);
  import swm_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = $clog2(2 * DEPTH);

  // item registers
  logic [FEE_W-1:0]  fee_r;
  logic [SIZE_W-1:0] size_r;
  logic [RATE_W-1:0] quo_r;
  logic [SIZE_W-1:0] rem_r;
  logic [STEP_W-1:0] step_r;
  logic [RATE_W-1:0] rate_r;
  logic              acc_r;

  // window state
  logic [CW-1:0] held_r;
  logic [IW-1:0] oldest_r;
  logic          bank_r;

  // merge pass state
  logic [CW-1:0]     rd_i_r;
  logic [CW-1:0]     wr_j_r;
  logic [CW-1:0]     n_new_r;
  logic [CW-1:0]     k_r;
  logic              ins_pend_r;
  logic              rem_pend_r;
  logic [RATE_W-1:0] med_r;

  logic [RATE_W-1:0] ring_mem [DEPTH];
  logic [RATE_W-1:0] ring_q;
  logic [RATE_W-1:0] sort_mem [2*DEPTH];
  logic [RATE_W-1:0] sort_q;

  logic              full;
  logic [CW:0]       slot_sum;
  logic [CW:0]       slot_wrap;
  logic [IW-1:0]     slot;
  logic [SIZE_W:0]   shifted;
  logic              ge;
  logic [SIZE_W:0]   diff;
  logic [SW-1:0]     raddr;
  logic [SW-1:0]     waddr;
  logic              s_we;
  logic [RATE_W-1:0] s_wdata;
  logic              ins_now;
  logic              rem_now;

  assign full = (held_r == CW'(DEPTH));

  assign slot_sum  = (CW+1)'(oldest_r) + (CW+1)'(held_r);
  assign slot_wrap = (slot_sum >= (CW+1)'(DEPTH)) ? slot_sum - (CW+1)'(DEPTH) : slot_sum;
  assign slot      = full ? oldest_r : slot_wrap[IW-1:0];

  // restoring division, one quotient bit per step
  assign shifted = {rem_r, quo_r[RATE_W-1]};
  assign ge      = (shifted >= {1'b0, size_r});
  assign diff    = shifted - {1'b0, size_r};

  assign stat.zero_size = (size_r == '0);
  assign stat.div_last  = (step_r == STEP_W'(DIV_STEPS - 1));
  assign stat.pass_end  = (rd_i_r == held_r);

  assign raddr = (bank_r ? SW'(DEPTH) : SW'(0)) + SW'(rd_i_r);
  assign waddr = (bank_r ? SW'(0) : SW'(DEPTH)) + SW'(wr_j_r);

  // merge decisions: insert before first larger entry, drop one evicted copy
  assign ins_now = cmd.cmp && ins_pend_r && (rate_r < sort_q);
  assign rem_now = cmd.cmp && !ins_now && rem_pend_r && (sort_q == ring_q);

  always_comb begin
    s_we    = 1'b0;
    s_wdata = sort_q;
    if (cmd.tail) begin
      s_we    = ins_pend_r;
      s_wdata = rate_r;
    end else if (ins_now) begin
      s_we    = 1'b1;
      s_wdata = rate_r;
    end else if (cmd.cmp && !rem_now) begin
      s_we    = 1'b1;
      s_wdata = sort_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ring && acc_r) begin
      ring_mem[slot] <= quo_r;
    end
    if (cmd.ring) begin
      ring_q <= ring_mem[oldest_r];
    end
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      sort_mem[waddr] <= s_wdata;
    end
    if (cmd.rd) begin
      sort_q <= sort_mem[raddr];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fee_r  <= in_fee;
      size_r <= in_size;
    end
    if (cmd.mul) begin
      // fee * 1000 as fee*1024 - fee*16 - fee*8
      quo_r <= {fee_r, 10'b0} - RATE_W'({fee_r, 4'b0}) - RATE_W'({fee_r, 3'b0});
      rem_r <= '0;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[RATE_W-2:0], ge};
      rem_r <= ge ? diff[SIZE_W-1:0] : shifted[SIZE_W-1:0];
    end
    if (cmd.mul) begin
      acc_r <= (size_r != '0);
    end
    if (cmd.ring) begin
      rate_r <= acc_r ? quo_r : '0;
    end
    if (s_we && (wr_j_r == k_r)) begin
      med_r <= s_wdata;
    end
    if (cmd.finish) begin
      res.accepted      <= acc_r;
      res.obs_rate      <= rate_r;
      res.fill_level    <= FILL_W'(n_new_r);
      res.used_fallback <= (n_new_r == '0);
      if (n_new_r == '0) begin
        res.estimate <= fallback_rate;
      end else begin
        res.estimate <= (med_r < floor_rate) ? floor_rate : med_r;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r     <= '0;
      held_r     <= '0;
      oldest_r   <= '0;
      bank_r     <= 1'b0;
      rd_i_r     <= '0;
      wr_j_r     <= '0;
      n_new_r    <= '0;
      k_r        <= '0;
      ins_pend_r <= 1'b0;
      rem_pend_r <= 1'b0;
    end else begin
      if (cmd.mul) begin
        step_r <= '0;
      end else if (cmd.div_step) begin
        step_r <= step_r + 1'b1;
      end
      if (cmd.ring) begin
        rd_i_r     <= '0;
        wr_j_r     <= '0;
        ins_pend_r <= acc_r;
        rem_pend_r <= acc_r && full;
        n_new_r    <= held_r + CW'(acc_r && !full);
        k_r        <= (held_r + CW'(acc_r && !full)) >> 1;
      end
      if (ins_now || (cmd.tail && ins_pend_r)) begin
        ins_pend_r <= 1'b0;
      end
      if (rem_now) begin
        rem_pend_r <= 1'b0;
      end
      if (s_we) begin
        wr_j_r <= wr_j_r + 1'b1;
      end
      if (cmd.cmp && !ins_now) begin
        rd_i_r <= rd_i_r + 1'b1;
      end
      if (cmd.finish) begin
        bank_r <= ~bank_r;
        held_r <= n_new_r;
        if (acc_r && full) begin
          oldest_r <= (oldest_r == IW'(DEPTH - 1)) ? '0 : oldest_r + 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/sliding_window_median_rate_top.sv =====
// sliding_window_median_rate_top: stream ports, configuration registers and
// result handshake around the median sequencer and datapath
// depends on swm_pkg, swm_ctrl, swm_dpath
//
// Each transfer on the input stream is one observation (fee, size). A nonzero
// size gives rate = fee*1000/size, which enters a window of the last
// WINDOW_DEPTH rates, pushing out the oldest one once the window is full; a zero
// size leaves the window alone. Every observation yields exactly one result:
// the rate, the accepted flag, the fill level and the estimate, which is the
// upper median of the window (sorted index count/2) floored at the rate floor
// register, or fallback_rate while the window is empty. For each item the divider
// retires all 57 quotient bits, one per cycle (skipped for a zero size), then a
// merge pass walks the sorted copy of the window, reading and comparing its
// entries in turn, writing the updated sorted copy into the other half of a
// ping-pong memory and picking off the median on the way. A new observation is
// taken as soon as the previous result sits in the output register. The sorted
// copy and the ring need no clearing after reset. Configuration writes are always
// ready; index 0 is fallback_rate, index 1 is the rate floor, other indexes are
// dropped.
module sliding_window_median_rate_top #(
  parameter int WINDOW_DEPTH = 1000
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [71:0]                        in_tdata,  // fee[46:0], obs_size[70:47], pad
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [127:0]                       out_tdata, // obs_rate[56:0], estimate[113:57],
                                                        // fill_level[123:114], pad
  output logic [1:0]                         out_tuser, // accepted[0], used_fallback[1]
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [swm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [swm_pkg::RATE_W-1:0]         cfg_data
);
  import swm_pkg::*;

  cmd_t    cmd;
  stat_t   stat;
  result_t res;

  logic              out_valid_r;
  logic [RATE_W-1:0] fallback_r;
  logic [RATE_W-1:0] floor_rate_r;
  logic              out_busy;

  // result slot stays busy until the consumer takes it
  assign out_busy  = out_valid_r && !out_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fallback_r   <= FALLBACK_RESET;
      floor_rate_r <= FLOOR_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_FALLBACK) begin
        fallback_r <= cfg_data;
      end else if (cfg_index == REG_FLOOR) begin
        floor_rate_r <= cfg_data;
      end
    end
  end

  // output valid: set when a result is written, cleared on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  swm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_busy (out_busy),
    .stat     (stat),
    .in_ready (in_tready),
    .cmd      (cmd)
  );

  swm_dpath #(
    .DEPTH (WINDOW_DEPTH)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_fee        (in_tdata[46:0]),
    .in_size       (in_tdata[70:47]),
    .fallback_rate (fallback_r),
    .floor_rate    (floor_rate_r),
    .stat          (stat),
    .res           (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, res.fill_level, res.estimate, res.obs_rate};
  assign out_tuser  = {res.used_fallback, res.accepted};

endmodule
